>>> rtl/core/smbd_pkg.sv
// smbd_pkg: shared types and constants for the SMBIOS record deframer
// result item layout, outcome codes and the result queue depth
// no dependencies
`timescale 1ns / 1ps

package smbd_pkg;

  typedef enum logic [1:0] {
    OUT_CLOSED     = 2'd0,
    OUT_INVALID    = 2'd1,
    OUT_END_RECORD = 2'd2,
    OUT_TABLE_END  = 2'd3
  } outcome_t;

  localparam logic [7:0] TYPE_BIOS_INFO  = 8'd0;
  localparam logic [7:0] TYPE_END_OF_TBL = 8'd127;
  localparam logic [7:0] MIN_LENGTH      = 8'd4;
  localparam logic [7:0] MAX_SHORT_BIOS  = 8'd9;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef struct packed {
    outcome_t    outcome;
    logic [7:0]  record_type;
    logic [15:0] record_handle;
    logic [7:0]  formatted_length;
    logic [15:0] record_size;
    logic        bios_info_seen;
    logic        last_of_run;
  } result_t;

  // results produced by one processed byte, first goes out before second
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

>>> rtl/core/smbd_walk.sv
// smbd_walk: per-byte walk state and result generation
// holds the record header, offset counter and zero-pair tracking
// depends on smbd_pkg
`timescale 1ns / 1ps

module smbd_walk #(
  parameter int OFFSET_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  logic [7:0]    table_byte,
  input  logic          table_last,
  output smbd_pkg::push_t push
);
  import smbd_pkg::*;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

  logic [OFFSET_BITS-1:0] offset_r, offset_nxt;
  logic [7:0]             type_r, type_nxt;
  logic [7:0]             length_r, length_nxt;
  logic [15:0]            handle_r, handle_nxt;
  logic                   prev_zero_r, prev_zero_nxt;
  logic                   bios_seen_r, bios_seen_nxt;
  logic                   stopped_r, stopped_nxt;

  function automatic logic [15:0] sat_size(input logic [OFFSET_BITS-1:0] off);
    logic [32:0] wide;
    wide = 33'(off);
    return (wide > 33'd65535) ? 16'hFFFF : wide[15:0];
  endfunction

  always_comb begin
    logic [OFFSET_BITS-1:0] off_inc;
    logic [32:0]            pos;
    logic                   have_first;
    result_t                first_res;
    result_t                final_res;

    off_inc       = (offset_r != OFF_MAX) ? offset_r + 1'b1 : offset_r;
    pos           = 33'(offset_r);
    have_first    = 1'b0;
    first_res     = '0;
    final_res     = '0;
    offset_nxt    = offset_r;
    type_nxt      = type_r;
    length_nxt    = length_r;
    handle_nxt    = handle_r;
    prev_zero_nxt = prev_zero_r;
    bios_seen_nxt = bios_seen_r;
    stopped_nxt   = stopped_r;

    if (!stopped_r) begin
      offset_nxt = off_inc;
      if (pos == 33'd0) begin
        type_nxt = table_byte;
      end else if (pos == 33'd1) begin
        length_nxt = table_byte;
      end else if (pos == 33'd2) begin
        handle_nxt = {handle_r[15:8], table_byte};
      end else if (pos == 33'd3) begin
        handle_nxt = {table_byte, handle_r[7:0]};
        if (length_r < MIN_LENGTH) begin
          have_first  = 1'b1;
          first_res.outcome = OUT_INVALID;
          stopped_nxt = 1'b1;
        end
      end else if (pos >= 33'(length_r)) begin
        if (table_byte == 8'd0 && prev_zero_r) begin
          have_first = 1'b1;
          if (type_r == TYPE_BIOS_INFO && length_r <= MAX_SHORT_BIOS) begin
            first_res.outcome = OUT_INVALID;
            stopped_nxt       = 1'b1;
          end else begin
            if (type_r == TYPE_BIOS_INFO) bios_seen_nxt = 1'b1;
            if (type_r == TYPE_END_OF_TBL) begin
              first_res.outcome = OUT_END_RECORD;
              stopped_nxt       = 1'b1;
            end else begin
              first_res.outcome = OUT_CLOSED;
            end
            offset_nxt    = '0;
            prev_zero_nxt = 1'b0;
          end
        end else begin
          prev_zero_nxt = (table_byte == 8'd0);
        end
      end
    end

    first_res.record_type      = type_nxt;
    first_res.record_handle    = handle_nxt;
    first_res.formatted_length = length_nxt;
    first_res.record_size      = sat_size(off_inc);
    first_res.bios_info_seen   = bios_seen_nxt;
    first_res.last_of_run      = !table_last;
    first_res.last_of_run      = table_last ? 1'b0 : 1'b1;

    // table end: an open record with a full header is invalid
    if (!stopped_nxt && 33'(offset_nxt) >= 33'd4) begin
      final_res.outcome          = OUT_INVALID;
      final_res.record_type      = type_nxt;
      final_res.record_handle    = handle_nxt;
      final_res.formatted_length = length_nxt;
      final_res.record_size      = sat_size(offset_nxt);
    end else begin
      final_res.outcome = OUT_TABLE_END;
    end
    final_res.bios_info_seen = bios_seen_nxt;
    final_res.last_of_run    = 1'b1;

    push = '0;
    if (fire) begin
      if (table_last) begin
        if (have_first) begin
          push.count  = 2'd2;
          push.first  = first_res;
          push.second = final_res;
        end else begin
          push.count = 2'd1;
          push.first = final_res;
        end
      end else if (have_first) begin
        push.count = 2'd1;
        push.first = first_res;
      end
    end

    if (table_last) begin
      offset_nxt    = '0;
      type_nxt      = '0;
      length_nxt    = '0;
      handle_nxt    = '0;
      prev_zero_nxt = 1'b0;
      bios_seen_nxt = 1'b0;
      stopped_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r    <= '0;
      type_r      <= '0;
      length_r    <= '0;
      handle_r    <= '0;
      prev_zero_r <= 1'b0;
      bios_seen_r <= 1'b0;
      stopped_r   <= 1'b0;
    end else if (fire) begin
      offset_r    <= offset_nxt;
      type_r      <= type_nxt;
      length_r    <= length_nxt;
      handle_r    <= handle_nxt;
      prev_zero_r <= prev_zero_nxt;
      bios_seen_r <= bios_seen_nxt;
      stopped_r   <= stopped_nxt;
    end
  end

endmodule

>>> rtl/core/smbd_out_queue.sv
// smbd_out_queue: small result queue taking up to two results per cycle
// holds finished results until the receiver takes them
// depends on smbd_pkg
`timescale 1ns / 1ps

module smbd_out_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  smbd_pkg::push_t   push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output smbd_pkg::result_t head
);
  import smbd_pkg::*;

  result_t             entry_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]   count_r, count_nxt;
  logic                pop;

  assign out_valid = (count_r != '0);
  assign head      = entry_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  // room for a worst-case pair of results
  assign room      = (count_r <= (QUEUE_AW + 1)'(QUEUE_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QUEUE_AW'(push.count);
    rd_ptr_nxt = rd_ptr_r + QUEUE_AW'(pop);
    count_nxt  = count_r + (QUEUE_AW + 1)'(push.count) - (QUEUE_AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) entry_r[wr_ptr_r] <= push.first;
    if (push.count == 2'd2) entry_r[wr_ptr_r + 1'b1] <= push.second;
  end

endmodule

>>> rtl/core/smbios_record_deframer.sv
// smbios_record_deframer: top level of the SMBIOS structure table deframer
// input register, walk logic and result queue
// depends on smbd_pkg, smbd_walk, smbd_out_queue
//
// Usage: table bytes enter on the in_ channel (valid/ready), one byte per
// transfer, in_table_last set on the final byte of a table. Results leave on
// the out_ channel (valid/ready), one result per transfer: record closed,
// layout invalid, end-of-table record closed, or table ended.
// A byte taken on in_ is held in the input register; when the queue has room
// the walk step pushes its results into the result queue, whose head is
// presented on out_. Throughput: one byte per cycle while the receiver keeps up;
// the result queue moves one result per cycle, so a byte that causes two
// results (a record closing on the last byte) needs two transfers downstream.
// The walk step fires only when the four-entry result queue has room for two
// results, so a stalled receiver backs up into in_ready after the queue fills.
// Reset clears the walk state and empties the queue; after the last byte of
// a table the walk returns to its reset state by itself.
`timescale 1ns / 1ps

module smbios_record_deframer #(
  parameter int OFFSET_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_table_byte,
  input  logic        in_table_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_outcome,
  output logic [7:0]  out_record_type,
  output logic [15:0] out_record_handle,
  output logic [7:0]  out_formatted_length,
  output logic [15:0] out_record_size,
  output logic        out_bios_info_seen,
  output logic        out_last_of_run
);
  import smbd_pkg::*;

  logic       hold_valid_r;
  logic [7:0] hold_byte_r;
  logic       hold_last_r;
  logic       room;
  logic       fire;
  push_t      push;
  result_t    head;

  assign fire     = hold_valid_r && room;
  assign in_ready = !hold_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid_r <= 1'b1;
    end else if (fire) begin
      hold_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte_r <= in_table_byte;
      hold_last_r <= in_table_last;
    end
  end

  smbd_walk #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .table_byte(hold_byte_r),
    .table_last(hold_last_r),
    .push      (push)
  );

  smbd_out_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head     (head)
  );

  assign out_outcome          = head.outcome;
  assign out_record_type      = head.record_type;
  assign out_record_handle    = head.record_handle;
  assign out_formatted_length = head.formatted_length;
  assign out_record_size      = head.record_size;
  assign out_bios_info_seen   = head.bios_info_seen;
  assign out_last_of_run      = head.last_of_run;

endmodule

>>> verif/smbios_record_deframer_test.sv
// smbios_record_deframer_test: self-checking testbench for the SMBIOS record deframer
// directed table and random structure tables, checked by a byte-level walk
// depends on smbd_pkg and smbios_record_deframer
`timescale 1ns / 1ps

module smbios_record_deframer_test;
  import smbd_pkg::*;

  localparam int          OFFSET_BITS = 16;
  localparam int unsigned OFFSET_MAX  = 32'((64'd1 << OFFSET_BITS) - 64'd1);
  localparam int          TARGET_BYTES   = 400;
  localparam int          TARGET_RESULTS = 40;
  localparam int          SETTLE_CYCLES  = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    result_t    want;
  } stim_row_t;

  localparam result_t END_CLEAN =
    '{OUT_TABLE_END, 8'h00, 16'h0000, 8'h00, 16'h0000, 1'b0, 1'b1};
  localparam result_t SHORT_HDR =
    '{OUT_INVALID, 8'h05, 16'h1234, 8'h02, 16'd4, 1'b0, 1'b1};
  localparam result_t NO_WANT = '0;

  localparam int DIRECTED_ROWS = 29;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // lone last byte right after reset
    '{8'h00, 1'b1, 1'b1, END_CLEAN},
    // header with length below the minimum, then ignored bytes up to the last one
    '{8'h05, 1'b0, 1'b0, NO_WANT},
    '{8'h02, 1'b0, 1'b0, NO_WANT},
    '{8'h34, 1'b0, 1'b0, NO_WANT},
    '{8'h12, 1'b0, 1'b1, SHORT_HDR},
    '{8'hFF, 1'b1, 1'b1, END_CLEAN},
    // bios information, length 10, zeros inside the formatted area do not close it
    '{8'h00, 1'b0, 1'b0, NO_WANT},
    '{8'h0A, 1'b0, 1'b0, NO_WANT},
    '{8'hCD, 1'b0, 1'b0, NO_WANT},
    '{8'hAB, 1'b0, 1'b0, NO_WANT},
    '{8'h00, 1'b0, 1'b0, NO_WANT},
    '{8'h00, 1'b0, 1'b0, NO_WANT},
    '{8'h00, 1'b0, 1'b0, NO_WANT},
    '{8'h00, 1'b0, 1'b0, NO_WANT},
    '{8'h00, 1'b0, 1'b0, NO_WANT},
    '{8'h00, 1'b0, 1'b0, NO_WANT},
    '{8'h00, 1'b0, 1'b0, NO_WANT},
    '{8'h00, 1'b0, 1'b0, NO_WANT},
    // end-of-table record closing on the last byte: two results
    '{8'h7F, 1'b0, 1'b0, NO_WANT},
    '{8'h04, 1'b0, 1'b0, NO_WANT},
    '{8'hFF, 1'b0, 1'b0, NO_WANT},
    '{8'hFF, 1'b0, 1'b0, NO_WANT},
    '{8'h00, 1'b0, 1'b0, NO_WANT},
    '{8'h00, 1'b1, 1'b0, NO_WANT},
    // table ends inside an open record
    '{8'h80, 1'b0, 1'b0, NO_WANT},
    '{8'h04, 1'b0, 1'b0, NO_WANT},
    '{8'h11, 1'b0, 1'b0, NO_WANT},
    '{8'h22, 1'b0, 1'b0, NO_WANT},
    '{8'hFF, 1'b1, 1'b0, NO_WANT}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_table_byte;
  logic        in_table_last;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_outcome;
  logic [7:0]  out_record_type;
  logic [15:0] out_record_handle;
  logic [7:0]  out_formatted_length;
  logic [15:0] out_record_size;
  logic        out_bios_info_seen;
  logic        out_last_of_run;

  smbios_record_deframer #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_table_byte       (in_table_byte),
    .in_table_last       (in_table_last),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_outcome         (out_outcome),
    .out_record_type     (out_record_type),
    .out_record_handle   (out_record_handle),
    .out_formatted_length(out_formatted_length),
    .out_record_size     (out_record_size),
    .out_bios_info_seen  (out_bios_info_seen),
    .out_last_of_run     (out_last_of_run)
  );

  // walk state of the predictor
  int unsigned rec_offset;
  logic [7:0]  hdr_type;
  logic [7:0]  hdr_length;
  logic [15:0] hdr_handle;
  logic        prev_zero;
  logic        bios_seen;
  logic        walk_stopped;

  result_t     step_out[$];
  result_t     pending_results[$];
  logic [7:0]  table_bytes[$];
  int          error_count;
  int          live_bytes;
  int          results_due;
  logic        no_idle;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #6_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int draw_idle();
    return no_idle ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic logic [15:0] size_so_far();
    return rec_offset > 65535 ? 16'hFFFF : 16'(rec_offset);
  endfunction

  function automatic result_t make_result(outcome_t oc, logic [7:0] typ, logic [15:0] handle,
                                          logic [7:0] len, logic [15:0] size);
    result_t r;
    r.outcome          = oc;
    r.record_type      = typ;
    r.record_handle    = handle;
    r.formatted_length = len;
    r.record_size      = size;
    r.bios_info_seen   = bios_seen;
    r.last_of_run      = 1'b0;
    return r;
  endfunction

  task automatic clear_walk();
    rec_offset   = 0;
    hdr_type     = '0;
    hdr_length   = '0;
    hdr_handle   = '0;
    prev_zero    = 1'b0;
    bios_seen    = 1'b0;
    walk_stopped = 1'b0;
  endtask

  task automatic predict_byte(input logic [7:0] data, input logic last);
    int unsigned pos;
    step_out.delete();
    if (!walk_stopped) begin
      pos = rec_offset;
      if (rec_offset < OFFSET_MAX) rec_offset++;
      if (pos == 0) begin
        hdr_type = data;
      end else if (pos == 1) begin
        hdr_length = data;
      end else if (pos == 2) begin
        hdr_handle[7:0] = data;
      end else if (pos == 3) begin
        hdr_handle[15:8] = data;
        if (hdr_length < MIN_LENGTH) begin
          step_out.push_back(make_result(OUT_INVALID, hdr_type, hdr_handle, hdr_length,
                                         size_so_far()));
          walk_stopped = 1'b1;
        end
      end else if (pos >= hdr_length) begin
        if (data == 8'h00 && prev_zero) begin
          if (hdr_type == TYPE_BIOS_INFO && hdr_length <= MAX_SHORT_BIOS) begin
            step_out.push_back(make_result(OUT_INVALID, hdr_type, hdr_handle, hdr_length,
                                           size_so_far()));
            walk_stopped = 1'b1;
          end else begin
            if (hdr_type == TYPE_BIOS_INFO) bios_seen = 1'b1;
            step_out.push_back(make_result(
              hdr_type == TYPE_END_OF_TBL ? OUT_END_RECORD : OUT_CLOSED,
              hdr_type, hdr_handle, hdr_length, size_so_far()));
            if (hdr_type == TYPE_END_OF_TBL) walk_stopped = 1'b1;
            rec_offset = 0;
            prev_zero  = 1'b0;
          end
        end else begin
          prev_zero = (data == 8'h00);
        end
      end
    end
    if (last) begin
      // open record with a full header counts as a broken layout
      if (!walk_stopped && rec_offset >= 4)
        step_out.push_back(make_result(OUT_INVALID, hdr_type, hdr_handle, hdr_length,
                                       size_so_far()));
      else
        step_out.push_back(make_result(OUT_TABLE_END, '0, '0, '0, '0));
      clear_walk();
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].last_of_run = 1'b1;
  endtask

  task automatic report(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want) report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  task automatic check_result();
    result_t want;
    if (pending_results.size() == 0) begin
      report("result transfer with nothing pending");
      return;
    end
    want = pending_results.pop_front();
    compare_field("outcome", 16'(out_outcome), 16'(want.outcome));
    compare_field("record_type", 16'(out_record_type), 16'(want.record_type));
    compare_field("record_handle", out_record_handle, want.record_handle);
    compare_field("formatted_length", 16'(out_formatted_length),
                  16'(want.formatted_length));
    compare_field("record_size", out_record_size, want.record_size);
    compare_field("bios_info_seen", 16'(out_bios_info_seen), 16'(want.bios_info_seen));
    compare_field("last_of_run", 16'(out_last_of_run), 16'(want.last_of_run));
  endtask

  task automatic send_byte(input logic [7:0] data, input logic last, input logic typed,
                           input result_t want);
    int gap;
    gap = draw_idle();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_table_byte <= data;
    in_table_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    live_bytes++;
    predict_byte(data, last);
    if (typed) pending_results.push_back(want);
    else foreach (step_out[i]) pending_results.push_back(step_out[i]);
    results_due += step_out.size();
  endtask

  task automatic drain_pending();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic build_record();
    logic [7:0] typ;
    logic [7:0] len;
    int         pick;
    int         strings;
    pick = $urandom_range(0, 15);
    if (pick < 3) typ = TYPE_BIOS_INFO;
    else if (pick == 3) typ = TYPE_END_OF_TBL;
    else typ = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 15);
    if (pick == 0) len = 8'($urandom_range(0, 3));
    else if (pick == 1) len = 8'($urandom_range(4, 40));
    else if (pick < 5) len = 8'($urandom_range(4, 10));
    else len = 8'($urandom_range(4, 24));
    table_bytes.push_back(typ);
    table_bytes.push_back(len);
    table_bytes.push_back(8'($urandom_range(0, 255)));
    table_bytes.push_back(8'($urandom_range(0, 255)));
    for (int i = 4; i < len; i++)
      table_bytes.push_back($urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom_range(0, 255)));
    strings = $urandom_range(0, 3);
    if (strings == 0) table_bytes.push_back(8'h00);
    for (int s = 0; s < strings; s++) begin
      repeat ($urandom_range(1, 6)) table_bytes.push_back(8'($urandom_range(1, 255)));
      table_bytes.push_back(8'h00);
    end
    table_bytes.push_back(8'h00);
  endtask

  task automatic build_table();
    int ending;
    table_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      // noise, zero-heavy
      repeat ($urandom_range(1, 12))
        table_bytes.push_back($urandom_range(0, 2) == 0 ? 8'h00 : 8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 4)) build_record();
      ending = $urandom_range(0, 7);
      if (ending == 0) begin
        repeat ($urandom_range(1, 3)) table_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (ending == 1 && table_bytes.size() > 1) begin
        repeat ($urandom_range(1, table_bytes.size() - 1)) void'(table_bytes.pop_back());
      end
    end
  endtask

  task automatic send_table();
    foreach (table_bytes[i]) send_byte(table_bytes[i], i == table_bytes.size() - 1, 1'b0, '0);
  endtask

  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = draw_idle();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      check_result();
    end
  end

  initial begin : table_source
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_table_byte = '0;
    in_table_last = 1'b0;
    no_idle       = 1'b0;
    error_count   = 0;
    live_bytes    = 0;
    results_due   = 0;
    clear_walk();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_byte(DIRECTED[i].data, DIRECTED[i].last, DIRECTED[i].typed, DIRECTED[i].want);
    drain_pending();

    while (live_bytes < TARGET_BYTES || results_due < TARGET_RESULTS) begin
      no_idle = ($urandom_range(0, 5) == 0);
      build_table();
      send_table();
      if ($urandom_range(0, 7) == 0) drain_pending();
    end
    no_idle = 1'b0;

    drain_pending();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> smbios_record_deframer.f
rtl/core/smbd_pkg.sv
rtl/core/smbd_walk.sv
rtl/core/smbd_out_queue.sv
rtl/core/smbios_record_deframer.sv
verif/smbios_record_deframer_test.sv
